// ===== hw/rtl/cdlb_pkg.sv =====
package cdlb_pkg;

  // field widths of the transfer channels
  localparam int OP_W        = 2;
  localparam int PRIO_W      = 3;
  localparam int GROUP_W     = 4;
  localparam int CORE_IDX_W  = 4;
  localparam int LOAD_IN_W   = 16;
  localparam int ENTRY_W     = 1;
  localparam int CHOSEN_W    = 4;
  localparam int MOVES_W     = 10;

  // configuration port
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int REG_SEL_BIT = 2;
  localparam int POLICY_W    = 2;
  localparam int CORES_REG_W = 5;
  localparam logic [POLICY_W-1:0]    RESET_POLICY = '0;
  localparam logic [CORES_REG_W-1:0] RESET_CORES  = 5'd16;

  // parameter defaults
  localparam int DEF_NUM_CORES         = 16;
  localparam int DEF_NUM_GROUPS        = 16;
  localparam int DEF_LOAD_WIDTH        = 16;
  localparam int DEF_MAX_BALANCE_STEPS = 1000;

  // policy constants
  localparam int MIN_CORES       = 2;
  localparam int PRIO_SECOND     = 3;
  localparam int BALANCE_SPREAD  = 5;
  localparam int BALANCE_DIVISOR = 10;

  typedef enum logic [OP_W-1:0] {
    OP_ASSIGN   = 2'd0,
    OP_LOAD_WR  = 2'd1,
    OP_GROUP_WR = 2'd2,
    OP_BALANCE  = 2'd3
  } op_t;

  typedef enum logic [POLICY_W-1:0] {
    POL_ROUND_ROBIN  = 2'd0,
    POL_LEAST_LOADED = 2'd1,
    POL_PRIORITY     = 2'd2,
    POL_AFFINITY     = 2'd3
  } policy_t;

  typedef enum logic {
    REG_POLICY_MODE  = 1'b0,
    REG_ACTIVE_CORES = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EVAL,
    S_DIV,
    S_WR_HI,
    S_WR_LO,
    S_DONE
  } state_t;

endpackage

// ===== hw/rtl/cdlb_in_if.sv =====
interface cdlb_in_if;
  logic                            valid;
  logic                            ready;
  logic [cdlb_pkg::OP_W-1:0]       op;
  logic [cdlb_pkg::PRIO_W-1:0]     thread_priority;
  logic [cdlb_pkg::GROUP_W-1:0]    thread_group;
  logic [cdlb_pkg::CORE_IDX_W-1:0] core_index;
  logic [cdlb_pkg::LOAD_IN_W-1:0]  load_value;
  logic [cdlb_pkg::ENTRY_W-1:0]    entry_valid;

  modport source (
    output valid, op, thread_priority, thread_group, core_index, load_value, entry_valid,
    input  ready
  );
  modport sink (
    input  valid, op, thread_priority, thread_group, core_index, load_value, entry_valid,
    output ready
  );
endinterface

// ===== hw/rtl/cdlb_out_if.sv =====
interface cdlb_out_if;
  logic                          valid;
  logic                          ready;
  logic [cdlb_pkg::CHOSEN_W-1:0] chosen_core;
  logic [cdlb_pkg::MOVES_W-1:0]  balance_moves;

  modport source (
    output valid, chosen_core, balance_moves,
    input  ready
  );
  modport sink (
    input  valid, chosen_core, balance_moves,
    output ready
  );
endinterface

// ===== hw/rtl/cdlb_load_mem.sv =====
module cdlb_load_mem #(
  parameter  int NUM_CORES  = cdlb_pkg::DEF_NUM_CORES,
  parameter  int LOAD_WIDTH = cdlb_pkg::DEF_LOAD_WIDTH,
  localparam int AW         = $clog2(NUM_CORES)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  logic [LOAD_WIDTH-1:0] wr_data,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output logic [LOAD_WIDTH-1:0] rd_data
);

  logic [LOAD_WIDTH-1:0] load_mem [NUM_CORES];
  logic [NUM_CORES-1:0]  written_r;
  logic [LOAD_WIDTH-1:0] q_r;
  logic                  q_ok_r;

  // storage array, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      load_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_r <= load_mem[rd_addr];
    end
  end

  // per-entry written flags, an entry never written reads as zero load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
      q_ok_r    <= 1'b0;
    end else begin
      if (wr_en) begin
        written_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        q_ok_r <= written_r[rd_addr];
      end
    end
  end

  assign rd_data = q_ok_r ? q_r : '0;

endmodule

// ===== hw/rtl/core_dispatch_load_balancer_top.sv =====
// load and group writes, and round-robin assign: go from accept to the done state directly
// scanning assign: scans cores 0..k-1, k = active core count clamped to 2..NUM_CORES
// balance: a scan, then each transfer step divides, writes two loads, rescans unless the
// step cap ends it; one core load read per cycle, reciprocal multiply for divide-by-ten
// one item at a time; the next item is taken while the previous result waits to be taken
// synchronous active-low reset: loads read zero, group entries unset, policy 0, 16 cores
module core_dispatch_load_balancer_top #(
  parameter int NUM_CORES         = cdlb_pkg::DEF_NUM_CORES,
  parameter int NUM_GROUPS        = cdlb_pkg::DEF_NUM_GROUPS,
  parameter int LOAD_WIDTH        = cdlb_pkg::DEF_LOAD_WIDTH,
  parameter int MAX_BALANCE_STEPS = cdlb_pkg::DEF_MAX_BALANCE_STEPS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  cdlb_in_if.sink                         in_ch,
  cdlb_out_if.source                      out_ch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [cdlb_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [cdlb_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [cdlb_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);

  localparam int CW     = $clog2(NUM_CORES);
  localparam int KW     = $clog2(NUM_CORES + 1);
  localparam int GW     = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int SW     = $clog2(MAX_BALANCE_STEPS + 1);
  localparam int LW     = LOAD_WIDTH;
  // reciprocal of ten scaled by 2**(LW+3), exact for every load below 2**LW
  localparam int DIV_SH = LW + 3;
  localparam logic [LW-1:0] DIV_MUL =
    LW'(((64'd1 << DIV_SH) + 64'(cdlb_pkg::BALANCE_DIVISOR - 1)) /
        64'(cdlb_pkg::BALANCE_DIVISOR));

  // configuration registers
  logic                                cfg_wr;
  cdlb_pkg::reg_idx_t                  cfg_reg;
  logic [cdlb_pkg::POLICY_W-1:0]       policy_r;
  logic [cdlb_pkg::CORES_REG_W-1:0]    cores_r;
  cdlb_pkg::policy_t                   policy;
  logic [KW-1:0]                       k_eff;

  // sequencer
  cdlb_pkg::state_t state_r, state_nxt;
  logic             acc;
  cdlb_pkg::op_t    in_op;
  cdlb_pkg::op_t    op_r;
  logic [cdlb_pkg::PRIO_W-1:0] prio_r;

  // round robin
  logic [CW-1:0] rr_r;
  logic [CW-1:0] rr_sel;
  logic [CW-1:0] rr_adv;

  // group store
  logic [NUM_GROUPS-1:0]             grp_valid_r;
  logic [cdlb_pkg::CORE_IDX_W-1:0]   grp_mem [NUM_GROUPS];
  logic [GW-1:0]                     grp_addr;
  logic                              grp_in_range;
  logic [cdlb_pkg::CORE_IDX_W-1:0]   pref_r;
  logic                              aff_ok_r;

  // load memory port
  logic          mem_wr_en;
  logic [CW-1:0] mem_wr_addr;
  logic [LW-1:0] mem_wr_data;
  logic          mem_rd_en;
  logic [CW-1:0] mem_rd_addr;
  logic [LW-1:0] mem_rd_data;

  // scan tracking
  logic [KW-1:0] rd_idx_r;
  logic          dv_r;
  logic [CW-1:0] didx_r;
  logic [LW-1:0] best_val_r, sec_val_r, hi_val_r, pref_val_r;
  logic [CW-1:0] best_idx_r, sec_idx_r, hi_idx_r;
  logic          sec_ok_r;

  // evaluation
  logic [LW-1:0] diff;
  logic [LW+2:0] min5;
  logic          aff_use;
  logic [CW-1:0] assign_pick;

  // balance step
  logic [LW-1:0]   div_q_r;
  logic [2*LW-1:0] div_prod;
  logic [LW-1:0]   div_quo;
  logic [LW-1:0]   move;
  logic [SW-1:0]   steps_r;
  logic [SW-1:0]   steps_inc;

  // result and output register
  logic [cdlb_pkg::CHOSEN_W-1:0] res_chosen_r;
  logic                          load_out;
  logic                          out_valid_r;
  logic [cdlb_pkg::CHOSEN_W-1:0] out_chosen_r;
  logic [cdlb_pkg::MOVES_W-1:0]  out_moves_r;

  // apb decode, always ready
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_reg    = cdlb_pkg::reg_idx_t'(cfg_paddr[cdlb_pkg::REG_SEL_BIT]);
  assign policy     = cdlb_pkg::policy_t'(policy_r);

  always_comb begin
    case (cfg_reg)
      cdlb_pkg::REG_POLICY_MODE:  cfg_prdata = cdlb_pkg::CFG_DATA_W'(policy_r);
      cdlb_pkg::REG_ACTIVE_CORES: cfg_prdata = cdlb_pkg::CFG_DATA_W'(cores_r);
      default:                    cfg_prdata = '0;
    endcase
  end

  // effective core count, clamped to 2..NUM_CORES
  always_comb begin
    if (32'(cores_r) < cdlb_pkg::MIN_CORES) begin
      k_eff = KW'(cdlb_pkg::MIN_CORES);
    end else if (32'(cores_r) > NUM_CORES) begin
      k_eff = KW'(NUM_CORES);
    end else begin
      k_eff = KW'(cores_r);
    end
  end

  // input handshake
  assign in_ch.ready = (state_r == cdlb_pkg::S_IDLE);
  assign acc         = in_ch.valid & in_ch.ready;
  assign in_op       = cdlb_pkg::op_t'(in_ch.op);

  // round-robin pick and advance
  assign rr_sel = (32'(rr_r) >= 32'(k_eff)) ? '0 : rr_r;
  assign rr_adv = (32'(rr_sel) + 32'd1 == 32'(k_eff)) ? '0 : rr_sel + CW'(1);

  // group address decode
  assign grp_addr     = GW'(in_ch.thread_group);
  assign grp_in_range = 32'(in_ch.thread_group) < NUM_GROUPS;

  // evaluation arithmetic
  assign diff      = hi_val_r - best_val_r;
  assign min5      = {3'b000, best_val_r} + {1'b0, best_val_r, 2'b00};
  assign aff_use   = aff_ok_r && (32'(pref_r) < 32'(k_eff)) &&
                     !({1'b0, pref_val_r} > min5[LW+2:2]);
  assign div_prod  = {{LW{1'b0}}, div_q_r} * {{LW{1'b0}}, DIV_MUL};
  assign div_quo   = LW'(div_prod[2*LW-1:DIV_SH]);
  assign move      = (div_q_r == '0) ? LW'(1) : div_q_r;
  assign steps_inc = steps_r + SW'(1);

  always_comb begin
    case (policy)
      cdlb_pkg::POL_PRIORITY: begin
        assign_pick = (32'(prio_r) >= cdlb_pkg::PRIO_SECOND) ? sec_idx_r : best_idx_r;
      end
      cdlb_pkg::POL_AFFINITY: begin
        assign_pick = aff_use ? CW'(pref_r) : best_idx_r;
      end
      default: begin
        assign_pick = best_idx_r;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cdlb_pkg::S_IDLE: begin
        if (acc) begin
          case (in_op)
            cdlb_pkg::OP_ASSIGN: begin
              state_nxt = (policy == cdlb_pkg::POL_ROUND_ROBIN) ? cdlb_pkg::S_DONE
                                                                : cdlb_pkg::S_SCAN;
            end
            cdlb_pkg::OP_BALANCE: state_nxt = cdlb_pkg::S_SCAN;
            default:              state_nxt = cdlb_pkg::S_DONE;
          endcase
        end
      end
      cdlb_pkg::S_SCAN: begin
        if (rd_idx_r == k_eff) begin
          state_nxt = cdlb_pkg::S_EVAL;
        end
      end
      cdlb_pkg::S_EVAL: begin
        if (op_r == cdlb_pkg::OP_BALANCE && diff > LW'(cdlb_pkg::BALANCE_SPREAD)) begin
          state_nxt = cdlb_pkg::S_DIV;
        end else begin
          state_nxt = cdlb_pkg::S_DONE;
        end
      end
      cdlb_pkg::S_DIV:   state_nxt = cdlb_pkg::S_WR_HI;
      cdlb_pkg::S_WR_HI: state_nxt = cdlb_pkg::S_WR_LO;
      cdlb_pkg::S_WR_LO: begin
        state_nxt = (steps_inc == SW'(MAX_BALANCE_STEPS)) ? cdlb_pkg::S_DONE
                                                          : cdlb_pkg::S_SCAN;
      end
      cdlb_pkg::S_DONE: begin
        if (load_out) begin
          state_nxt = cdlb_pkg::S_IDLE;
        end
      end
      default: state_nxt = cdlb_pkg::S_IDLE;
    endcase
  end

  // memory port control per state
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = CW'(in_ch.core_index);
    mem_wr_data = LW'(in_ch.load_value);
    mem_rd_en   = 1'b0;
    mem_rd_addr = rd_idx_r[CW-1:0];
    load_out    = 1'b0;
    case (state_r)
      cdlb_pkg::S_IDLE: begin
        mem_wr_en = acc && in_op == cdlb_pkg::OP_LOAD_WR &&
                    32'(in_ch.core_index) < NUM_CORES;
      end
      cdlb_pkg::S_SCAN: begin
        mem_rd_en = rd_idx_r < k_eff;
      end
      cdlb_pkg::S_WR_HI: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = hi_idx_r;
        mem_wr_data = hi_val_r - move;
      end
      cdlb_pkg::S_WR_LO: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = best_idx_r;
        mem_wr_data = best_val_r + move;
      end
      cdlb_pkg::S_DONE: begin
        load_out = !out_valid_r || out_ch.ready;
      end
      default: begin
        mem_wr_en = 1'b0;
      end
    endcase
  end

  cdlb_load_mem #(
    .NUM_CORES  (NUM_CORES),
    .LOAD_WIDTH (LOAD_WIDTH)
  ) u_load_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cdlb_pkg::S_IDLE;
      policy_r    <= cdlb_pkg::RESET_POLICY;
      cores_r     <= cdlb_pkg::RESET_CORES;
      rr_r        <= '0;
      grp_valid_r <= '0;
      rd_idx_r    <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // configuration writes; a core count write restarts round robin
      if (cfg_wr && cfg_reg == cdlb_pkg::REG_POLICY_MODE) begin
        policy_r <= cfg_pwdata[cdlb_pkg::POLICY_W-1:0];
      end
      if (cfg_wr && cfg_reg == cdlb_pkg::REG_ACTIVE_CORES) begin
        cores_r <= cfg_pwdata[cdlb_pkg::CORES_REG_W-1:0];
        rr_r    <= '0;
      end else if (acc && in_op == cdlb_pkg::OP_ASSIGN &&
                   policy == cdlb_pkg::POL_ROUND_ROBIN) begin
        rr_r <= rr_adv;
      end
      // group entry flags
      if (acc && in_op == cdlb_pkg::OP_GROUP_WR && grp_in_range) begin
        grp_valid_r[grp_addr] <= in_ch.entry_valid[0];
      end
      // scan read index, restarts on every entry to the scan state
      if (state_r == cdlb_pkg::S_SCAN) begin
        if (mem_rd_en) begin
          rd_idx_r <= rd_idx_r + KW'(1);
        end
      end else begin
        rd_idx_r <= '0;
      end
      dv_r <= mem_rd_en;
      // output register
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // group entry core store, registered read at accept
  always_ff @(posedge clk) begin
    if (acc && in_op == cdlb_pkg::OP_GROUP_WR && grp_in_range) begin
      grp_mem[grp_addr] <= in_ch.core_index;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      pref_r   <= grp_mem[grp_addr];
      aff_ok_r <= grp_in_range && grp_valid_r[grp_addr];
      op_r     <= in_op;
      prio_r   <= in_ch.thread_priority;
    end
  end

  // running minimum, second minimum and maximum over the streamed loads
  always_ff @(posedge clk) begin
    didx_r <= mem_rd_addr;
    if (dv_r) begin
      if (didx_r == '0) begin
        best_val_r <= mem_rd_data;
        best_idx_r <= '0;
        hi_val_r   <= mem_rd_data;
        hi_idx_r   <= '0;
        sec_ok_r   <= 1'b0;
      end else begin
        if (mem_rd_data < best_val_r) begin
          best_val_r <= mem_rd_data;
          best_idx_r <= didx_r;
          sec_val_r  <= best_val_r;
          sec_idx_r  <= best_idx_r;
          sec_ok_r   <= 1'b1;
        end else if (!sec_ok_r || mem_rd_data < sec_val_r) begin
          sec_val_r <= mem_rd_data;
          sec_idx_r <= didx_r;
          sec_ok_r  <= 1'b1;
        end
        if (mem_rd_data > hi_val_r) begin
          hi_val_r <= mem_rd_data;
          hi_idx_r <= didx_r;
        end
      end
      // capture the preferred core's load as it streams past
      if (32'(didx_r) == 32'(pref_r)) begin
        pref_val_r <= mem_rd_data;
      end
    end
  end

  // spread registered in the evaluate state, divided by ten by reciprocal multiply in the divide state
  always_ff @(posedge clk) begin
    if (state_r == cdlb_pkg::S_EVAL) begin
      div_q_r <= diff;
    end else if (state_r == cdlb_pkg::S_DIV) begin
      div_q_r <= div_quo;
    end
  end

  // result fields
  always_ff @(posedge clk) begin
    if (acc) begin
      steps_r      <= '0;
      res_chosen_r <= (in_op == cdlb_pkg::OP_ASSIGN && policy == cdlb_pkg::POL_ROUND_ROBIN)
                      ? cdlb_pkg::CHOSEN_W'(rr_sel) : '0;
    end else if (state_r == cdlb_pkg::S_EVAL && op_r == cdlb_pkg::OP_ASSIGN) begin
      res_chosen_r <= cdlb_pkg::CHOSEN_W'(assign_pick);
    end else if (state_r == cdlb_pkg::S_WR_LO) begin
      steps_r <= steps_inc;
    end
    if (load_out) begin
      out_chosen_r <= res_chosen_r;
      out_moves_r  <= cdlb_pkg::MOVES_W'(steps_r);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.chosen_core   = out_chosen_r;
  assign out_ch.balance_moves = out_moves_r;

endmodule

// ===== hw/rtl/cdlb_checker.sv =====
module cdlb_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [cdlb_pkg::CHOSEN_W-1:0] out_chosen_core,
  input logic [cdlb_pkg::MOVES_W-1:0]  out_balance_moves
);

  logic       in_xfer;
  logic       out_xfer;
  logic [1:0] pend_r;

  assign in_xfer  = in_valid & in_ready;
  assign out_xfer = out_valid & out_ready;

  // items accepted whose result has not been taken yet
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 2'(in_xfer) - 2'(out_xfer);
    end
  end

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transfer");

  // a stalled result keeps its fields
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_chosen_core) && $stable(out_balance_moves))
    else $error("result fields changed while stalled");

  // one item in work at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ready)
    else $error("input taken again right after a transfer");

  // no result without an item behind it
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result offered with no item outstanding");

  // at most one item working and one result waiting
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("too many items outstanding");

endmodule

bind core_dispatch_load_balancer_top cdlb_checker u_cdlb_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_chosen_core   (out_ch.chosen_core),
  .out_balance_moves (out_ch.balance_moves)
);
